// ===== design/fm_pkg.sv =====
package fm_pkg;
	localparam logic [31:0] QNAN_CODE    = 32'h7FF80001;
	localparam logic [31:0] INF_NAN_CODE = 32'h7F800001;
	localparam logic [31:0] INF_BITS     = 32'h7F800000;
	localparam logic [7:0]  EXP_MAX      = 8'hFF;
	localparam logic [9:0]  EXP_BIAS     = 10'd127;

	typedef struct packed {
		logic        special;
		logic [31:0] special_val;
		logic        sign;
		logic [9:0]  exp_sum;
	} fm_ctl_t;
endpackage

// ===== design/fm_cell.sv =====
module fm_cell #(
	parameter int BITS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                vin,
	input  logic [47:0]         a_in,
	input  logic [23:0]         b_in,
	input  logic [47:0]         acc_in,
	input  fm_pkg::fm_ctl_t     ctl_in,
	output logic                vout,
	output logic [47:0]         a_out,
	output logic [23:0]         b_out,
	output logic [47:0]         acc_out,
	output fm_pkg::fm_ctl_t     ctl_out
);
	import fm_pkg::*;

	logic [BITS-1:0] digit;
	logic [47:0]     part;

	assign digit = b_in[BITS-1:0];
	assign part  = a_in * 48'(digit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout <= 1'b0;
		end else begin
			vout <= vin;
		end
	end

	always_ff @(posedge clk) begin
		a_out   <= a_in << BITS;
		b_out   <= b_in >> BITS;
		acc_out <= acc_in + part;
		ctl_out <= ctl_in;
	end
endmodule

// ===== design/float32_multiplier.sv =====
// channel | valid       | payload
// input   | start&!busy | a_bits, b_bits
// output  | done        | product_bits
// One word accepted every cycle; busy is never raised.
// Pipeline: three cells of eight-bit partial product plus one output stage.
// Reset clears the valid chain only; results already in flight are dropped.
// The receiver cannot stall; each result shows for one cycle.
module float32_multiplier (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] a_bits,
	input  logic [31:0] b_bits,
	output logic        done,
	output logic [31:0] product_bits
);
	import fm_pkg::*;

	localparam int NCELL = 3;

	logic        v   [NCELL+1];
	logic [47:0] ma  [NCELL+1];
	logic [23:0] mb  [NCELL+1];
	logic [47:0] acc [NCELL+1];
	fm_ctl_t     ctl [NCELL+1];

	logic [7:0]  ea, eb;
	logic [22:0] fa, fb;
	logic        sg;
	fm_ctl_t     c0;

	assign busy = 1'b0;
	assign ea = a_bits[30:23];
	assign eb = b_bits[30:23];
	assign fa = a_bits[22:0];
	assign fb = b_bits[22:0];
	assign sg = a_bits[31] ^ b_bits[31];

	always_comb begin
		c0.sign        = sg;
		c0.exp_sum     = {2'b0, ea} + {2'b0, eb};
		c0.special     = 1'b1;
		c0.special_val = {sg, 31'b0};
		if (ea == EXP_MAX && fa != 23'd0) begin
			c0.special_val = QNAN_CODE;
		end else if (eb == EXP_MAX && fb != 23'd0) begin
			c0.special_val = QNAN_CODE;
		end else if (ea == EXP_MAX) begin
			c0.special_val = (eb == 8'd0) ? INF_NAN_CODE : (INF_BITS | {sg, 31'b0});
		end else if (eb == EXP_MAX) begin
			c0.special_val = (ea == 8'd0) ? INF_NAN_CODE : (INF_BITS | {sg, 31'b0});
		end else if (ea == 8'd0 || eb == 8'd0) begin
			c0.special_val = {sg, 31'b0};
		end else begin
			c0.special = 1'b0;
		end
	end

	assign v[0]   = start;
	assign ma[0]  = {24'd0, 1'b1, fa};
	assign mb[0]  = {1'b1, fb};
	assign acc[0] = 48'd0;
	assign ctl[0] = c0;

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		fm_cell #(.BITS(8)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.vin(v[i]), .a_in(ma[i]), .b_in(mb[i]), .acc_in(acc[i]), .ctl_in(ctl[i]),
			.vout(v[i+1]), .a_out(ma[i+1]), .b_out(mb[i+1]), .acc_out(acc[i+1]),
			.ctl_out(ctl[i+1])
		);
	end

	logic [24:0] prod;
	logic        norm;
	logic [22:0] mant;
	logic [9:0]  ex;
	logic [31:0] res;
	fm_ctl_t     cf;

	assign cf   = ctl[NCELL];
	assign prod = acc[NCELL][47:23];
	assign norm = prod[24];
	assign mant = norm ? prod[23:1] : prod[22:0];
	assign ex   = cf.exp_sum - EXP_BIAS + {9'd0, norm};

	always_comb begin
		if (cf.special) begin
			res = cf.special_val;
		end else if (cf.exp_sum + {9'd0, norm} <= EXP_BIAS) begin
			res = {cf.sign, 31'b0};
		end else if (ex >= 10'd255) begin
			res = INF_BITS | {cf.sign, 31'b0};
		end else begin
			res = {cf.sign, ex[7:0], mant};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v[NCELL];
		end
	end

	always_ff @(posedge clk) begin
		product_bits <= res;
	end
endmodule

// ===== design/fm_checker.sv =====
module fm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [31:0] product_bits
);
	a_busy_low: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##4 done) else $error("result missing");
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 4)) else $error("spurious result");
	a_nan: assert property (@(posedge clk) disable iff (!arst_n)
		(done && product_bits[30:23] == 8'hFF) |->
		(product_bits[22:0] == 23'd0 || product_bits == 32'h7FF80001 ||
		 product_bits == 32'h7F800001)) else $error("bad special code");
endmodule

bind float32_multiplier fm_checker u_fm_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.done(done), .product_bits(product_bits)
);

// ===== dv/fm_checker.sv =====
`timescale 1ns / 1ps

module tb_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [31:0] a_bits,
	input  logic [31:0] b_bits,
	input  logic        done,
	input  logic [31:0] product_bits,
	output int          fail_count,
	output int          pending_count,
	output int          product_count
);
	import fm_pkg::*;

	logic [31:0] product_queue[$];

	function automatic logic [31:0] predict_product(logic [31:0] a, logic [31:0] b);
		logic        sgn;
		logic [7:0]  ea, eb;
		logic [22:0] fa, fb;
		logic [47:0] full;
		logic [24:0] prod;
		logic        norm;
		logic [23:0] mant;
		int          ex;
		sgn = a[31] ^ b[31];
		ea = a[30:23];
		eb = b[30:23];
		fa = a[22:0];
		fb = b[22:0];
		if (ea == EXP_MAX && fa != 0)
			return QNAN_CODE;
		if (eb == EXP_MAX && fb != 0)
			return QNAN_CODE;
		if (ea == EXP_MAX)
			return (eb == 0) ? INF_NAN_CODE : (INF_BITS | {sgn, 31'b0});
		if (eb == EXP_MAX)
			return (ea == 0) ? INF_NAN_CODE : (INF_BITS | {sgn, 31'b0});
		if (ea == 0 || eb == 0)
			return {sgn, 31'b0};
		full = {1'b1, fa} * {1'b1, fb};
		prod = full[47:23];
		norm = prod[24];
		mant = norm ? prod[24:1] : prod[23:0];
		ex = int'(ea) + int'(eb) - 127 + int'(norm);
		if (ex >= 255)
			return INF_BITS | {sgn, 31'b0};
		if (ex <= 0)
			return {sgn, 31'b0};
		return {sgn, ex[7:0], mant[22:0]};
	endfunction

	assign pending_count = product_queue.size();

	always @(posedge clk or negedge arst_n) begin
		logic [31:0] want;
		if (!arst_n) begin
			fail_count <= 0;
			product_count <= 0;
		end else begin
			if (done) begin
				product_count <= product_count + 1;
				if (product_queue.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected word: product_bits=%h", product_bits);
					fail_count <= fail_count + 1;
				end else begin
					want = product_queue.pop_front();
					if (want !== product_bits) begin
						if (fail_count < 10)
							$display("mismatch product_bits: expected %h actual %h",
								want, product_bits);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (start && !busy)
				product_queue.push_back(predict_product(a_bits, b_bits));
		end
	end
endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import fm_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [31:0] a_bits;
	logic [31:0] b_bits;
	logic        done;
	logic [31:0] product_bits;
	int          fail_count;
	int          pending_count;
	int          product_count;
	int          word_count;
	int          gap_pct;

	float32_multiplier i_dut (.*);

	tb_checker i_checker (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("** float32_multiplier: FAILED **");
		$finish;
	end

	function automatic logic [31:0] random_float();
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(0, 9))
			0: v[30:23] = EXP_MAX;
			1: v[30:23] = 8'h00;
			2: v[30:23] = 8'($urandom_range(1, 20));
			3: v[30:23] = 8'($urandom_range(235, 254));
			4: v[22:0] = $urandom_range(0, 1) ? 23'h7FFFFF : 23'h0;
			default: v[30:23] = 8'($urandom_range(64, 190));
		endcase
		return v;
	endfunction

	task automatic send_word(input logic [31:0] a, input logic [31:0] b);
		while ($urandom_range(0, 99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		a_bits <= a;
		b_bits <= b;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		word_count++;
	endtask

	initial begin
		logic [31:0] edge_vals[12];
		edge_vals = '{32'h00000000, 32'h80000000, 32'h00000001, 32'h3F800000,
			32'hBFFFFFFF, 32'h7F7FFFFF, 32'h00800000, 32'h7F800000,
			32'hFF800000, 32'h7FC00000, 32'hFF800001, 32'h807FFFFF};
		arst_n = 0;
		start = 0;
		a_bits = 0;
		b_bits = 0;
		word_count = 0;
		gap_pct = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < 12; i++)
			send_word(edge_vals[i], edge_vals[(i * 5 + 3) % 12]);
		send_word(32'h7F800000, 32'h00000001);
		send_word(32'h3F800000, 32'h7FC00001);
		send_word(32'h7F000000, 32'h7F000000);
		send_word(32'h00800000, 32'h00800000);
		send_word(32'h3FFFFFFF, 32'h3FFFFFFF);
		send_word(32'hC0000000, 32'h40400000);
		start <= 1'b0;
		while (pending_count != 0)
			@(posedge clk);
		for (int ph = 0; ph < 3; ph++) begin
			gap_pct = (ph == 0) ? 19 : (ph == 1) ? 56 : 0;
			repeat (310)
				send_word(random_float(), random_float());
		end
		start <= 1'b0;
		for (int k = 0; k < 1000 && pending_count != 0; k++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		$display("covered %0d multiplies: special operands, extreme exponents, three gap mixes",
			word_count);
		$display("%0d products checked, %0d left pending", product_count, pending_count);
		if (fail_count == 0 && pending_count == 0)
			$display("** float32_multiplier: PASSED **");
		else
			$display("** float32_multiplier: FAILED **");
		$finish;
	end
endmodule

// ===== float32_multiplier.f =====
design/fm_pkg.sv
design/fm_cell.sv
design/float32_multiplier.sv
design/fm_checker.sv
dv/fm_checker.sv
dv/tb_top.sv
